// File: rtl/core/spq_pkg.sv
// Types and constants shared by the stable priority queue.
package spq_pkg;

  localparam int unsigned DefCapacity = 64;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] tag;
    logic [15:0] severity;
  } req_t;

  typedef struct packed {
    logic [15:0] out_tag;
    logic [15:0] out_severity;
    logic [1:0]  status;
    logic [6:0]  occupancy;
  } rsp_t;

endpackage

// File: rtl/core/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue: sequencer, scan and shift datapath.
//
//   channel   ports                    handshake
//   request   start_i, req_i, busy_o   taken when start_i high and busy_o low
//   result    done_o, rsp_o            one cycle, done_o high, no backpressure
//
// Insert, clear, no-op and flagged requests are handled in the accept cycle (result the next).
// Extract reads the entry RAM once per cycle through one read port: a scan of
// all N entries, a shift pass that moves each entry after the winner down by one
// slot, up to the tail, and a finish state; busy_o stays high through all three,
// result the cycle after the finish state.
// Reset empties the queue; stored entries are not cleared.
// The receiver cannot stall; busy_o stays high until the result cycle.
module stable_priority_queue #(
  parameter int unsigned Capacity = spq_pkg::DefCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  spq_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output spq_pkg::rsp_t rsp_o
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  fsm_e          state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] best_q, best_d;
  logic [31:0]   best_word_q, best_word_d;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;

  logic          accept;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [31:0]   rdata;
  logic [CW-1:0] count_m1;
  logic          issue;
  logic          scan_last;
  logic          shift_end;
  logic          take_new;

  spq_ram #(
    .Width(32),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign accept    = start_i && (state_q == S_IDLE);
  assign count_m1  = count_q - CW'(1);
  assign issue     = (idx_q < count_q);
  assign scan_last = rd_vld_q && (rd_idx_q == count_m1[AW-1:0]);
  assign shift_end = !issue && !rd_vld_q;
  assign take_new  = (rd_idx_q == '0) || (rdata[15:0] > best_word_q[15:0]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_i.cmd == CMD_EXTRACT) && (count_q != '0)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (shift_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    best_d      = best_q;
    best_word_d = best_word_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = count_q[AW-1:0];
    wdata       = {req_i.tag, req_i.severity};
    re          = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d             = 1'b1;
          rsp_d.out_tag      = '0;
          rsp_d.out_severity = '0;
          rsp_d.status       = ST_DONE;
          idx_d              = '0;
          unique case (req_i.cmd)
            CMD_INSERT: begin
              if (count_q == CW'(Capacity)) begin
                rsp_d.status = ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_EXTRACT: begin
              if (count_q == '0) begin
                rsp_d.status = ST_EMPTY;
              end else begin
                done_d = 1'b0;
              end
            end
            CMD_CLEAR: count_d = '0;
            default:   count_d = count_q;
          endcase
          rsp_d.occupancy = 7'(count_d);
        end
      end
      S_SCAN: begin
        if (issue) begin
          re       = 1'b1;
          idx_d    = idx_q + CW'(1);
          rd_idx_d = idx_q[AW-1:0];
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && take_new) begin
          best_d      = rd_idx_q;
          best_word_d = rdata;
        end
        if (scan_last) begin
          idx_d = CW'(best_d) + CW'(1);
        end
      end
      S_SHIFT: begin
        if (issue) begin
          re       = 1'b1;
          idx_d    = idx_q + CW'(1);
          rd_idx_d = idx_q[AW-1:0];
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          we    = 1'b1;
          waddr = rd_idx_q - AW'(1);
          wdata = rdata;
        end
      end
      S_FINISH: begin
        count_d            = count_m1;
        done_d             = 1'b1;
        rsp_d.out_tag      = best_word_q[31:16];
        rsp_d.out_severity = best_word_q[15:0];
        rsp_d.status       = ST_DONE;
        rsp_d.occupancy    = 7'(count_m1);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_q      <= best_d;
    best_word_q <= best_word_d;
    rsp_q       <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
